// File: src/osset_pkg.sv
// Shared types and constants for the order statistic set.
// Used by the cell, the group reducer and the top level; depends on nothing.
package osset_pkg;

  localparam int KEY_W        = 32;
  localparam int CNT_OUT_W    = 11;
  localparam int DEF_CAPACITY = 1024;
  localparam int GROUP_SIZE   = 32;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_INS = 2'd0;
  localparam logic [1:0] REQ_DEL = 2'd1;
  localparam logic [1:0] REQ_CNT = 2'd2;
  localparam logic [1:0] REQ_SEL = 2'd3;

  // Result status codes carried on the output tuser.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_BADRANK = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic ld_flags;
    logic do_ins;
    logic do_del;
  } cell_ctrl_t;

endpackage

// File: src/osset_cell.sv
// One storage cell of the sorted chain: holds a key, compares it with the
// broadcast operand and shifts left or right with its neighbors. Uses osset_pkg.
module osset_cell #(
  parameter int CNT_W = 11,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  osset_pkg::cell_ctrl_t         ctrl,
  input  logic [CNT_W-1:0]              count,
  input  logic [osset_pkg::KEY_W-1:0]   op,
  input  logic                          left_lt,
  input  logic [osset_pkg::KEY_W-1:0]   left_key,
  input  logic [osset_pkg::KEY_W-1:0]   right_key,
  output logic                          lt_r,
  output logic                          eq_r,
  output logic [osset_pkg::KEY_W-1:0]   key_r
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic                        valid_w;
  logic                        lt_nxt;
  logic                        eq_nxt;
  logic [osset_pkg::KEY_W-1:0] key_nxt;

  assign valid_w = IDX_C < count;

  always_comb begin
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    key_nxt = key_r;
    if (ctrl.ld_flags) begin
      lt_nxt = valid_w && ($signed(key_r) < $signed(op));
      eq_nxt = valid_w && (key_r == op);
    end
    // Cells at or past the insertion point move right; the boundary cell takes the new key.
    if (ctrl.do_ins && !lt_r) begin
      key_nxt = left_lt ? op : left_key;
    end else if (ctrl.do_del && !lt_r) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// File: src/osset_group.sv
// Registered reduction over one group of cells: boundary position, match flag
// and the key at a chosen local index. Uses osset_pkg.
module osset_group #(
  parameter int GRP = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic                                  left_lt,
  input  logic [GRP-1:0]                        lt,
  input  logic [GRP-1:0]                        eq,
  input  logic [GRP-1:0][osset_pkg::KEY_W-1:0]  keys,
  input  logic [$clog2(GRP)-1:0]                sel_loc,
  output logic                                  hasb_r,
  output logic [$clog2(GRP)-1:0]                bidx_r,
  output logic                                  eqany_r,
  output logic [osset_pkg::KEY_W-1:0]           key_r
);

  localparam int LW = $clog2(GRP);

  logic          hasb_nxt;
  logic [LW-1:0] bidx_nxt;
  logic          eqany_nxt;
  logic [GRP-1:0] bnd;

  // The lt flags form a prefix, so at most one cell in the whole chain is a boundary.
  always_comb begin
    hasb_nxt = 1'b0;
    bidx_nxt = '0;
    for (int i = 0; i < GRP; i++) begin
      bnd[i] = !lt[i] && ((i == 0) ? left_lt : lt[(i == 0) ? 0 : i - 1]);
      hasb_nxt = hasb_nxt | bnd[i];
      bidx_nxt = bidx_nxt | (bnd[i] ? LW'(i) : '0);
    end
    eqany_nxt = |eq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hasb_r  <= 1'b0;
      eqany_r <= 1'b0;
    end else if (load) begin
      hasb_r  <= hasb_nxt;
      eqany_r <= eqany_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bidx_r <= bidx_nxt;
      key_r  <= keys[sel_loc];
    end
  end

endmodule

// File: src/order_statistic_set.sv
// Order statistic set: sorted chain of key cells with a two-level registered rank tree.
// A request steps through compare, group reduce and finish; the result beat is registered
// in the finish step, which waits while the output is stalled. One request is in flight
// at a time, so no new request is accepted until the previous one has left the finish step.
// Reset (rst_n low, synchronous) empties the set and clears all handshake state.
module order_statistic_set #(
  parameter int CAPACITY = osset_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [10:0] smaller_count, [42:11] selected_key, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int KW     = osset_pkg::KEY_W;
  localparam int OW     = osset_pkg::CNT_OUT_W;
  localparam int GRP    = osset_pkg::GROUP_SIZE;
  localparam int LW     = $clog2(GRP);
  localparam int NGROUP = CAPACITY / GRP + 1;
  localparam int GW     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
  localparam int NSLOT  = NGROUP * GRP;
  localparam int PW     = GW + LW;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_GRP  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [1:0]      phase_r, phase_nxt;
  logic [KW-1:0]   op_r;
  logic [1:0]      kind_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic            sel_ok_r;
  logic [GW-1:0]   sel_grp_r;
  logic [LW-1:0]   sel_loc_r;

  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [OW-1:0]   out_count_r;
  logic [KW-1:0]   out_key_r;

  logic                        in_acc;
  logic                        fin_go;
  osset_pkg::cell_ctrl_t       ctrl;

  logic [NSLOT-1:0]            slot_lt;
  logic [NSLOT-1:0]            slot_eq;
  logic [NSLOT-1:0][KW-1:0]    slot_key;

  logic [NGROUP-1:0]           grp_hasb;
  logic [NGROUP-1:0]           grp_eq;
  logic [NGROUP-1:0][LW-1:0]   grp_bidx;
  logic [NGROUP-1:0][KW-1:0]   grp_key;

  logic [PW-1:0]    pos_w;
  logic [PW+OW-1:0] pos_ext;
  logic             present_w;
  logic             full_w;
  logic             do_ins_w;
  logic             do_del_w;
  logic [1:0]       status_w;

  logic [32:0]      op33;
  logic [32:0]      cnt33;
  logic [KW-1:0]    idx_w;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (phase_r == PH_IDLE);
  assign fin_go    = (phase_r == PH_FIN) && (!out_valid_r || out_tready);

  // Rank check for select, taken from the registered operand.
  assign op33  = {op_r[KW-1], op_r};
  assign cnt33 = {{(33 - CNT_W){1'b0}}, count_r};
  assign idx_w = op_r - KW'(1);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: if (in_acc) phase_nxt = PH_CMP;
      PH_CMP:  phase_nxt = PH_GRP;
      PH_GRP:  phase_nxt = PH_FIN;
      PH_FIN:  if (fin_go) phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Final level of the rank tree and the request decision.
  always_comb begin
    pos_w = '0;
    for (int g = 0; g < NGROUP; g++) begin
      pos_w = pos_w | (grp_hasb[g] ? {GW'(g), grp_bidx[g]} : '0);
    end
    pos_ext   = {{OW{1'b0}}, pos_w};
    present_w = |grp_eq;
    full_w    = (count_r == CAP_C);
    do_ins_w  = (kind_r == osset_pkg::REQ_INS) && !present_w && !full_w;
    do_del_w  = (kind_r == osset_pkg::REQ_DEL) && present_w;
    status_w  = osset_pkg::ST_DONE;
    if ((kind_r == osset_pkg::REQ_INS) && !present_w && full_w) begin
      status_w = osset_pkg::ST_FULL;
    end else if ((kind_r == osset_pkg::REQ_SEL) && !sel_ok_r) begin
      status_w = osset_pkg::ST_BADRANK;
    end
    count_nxt = count_r;
    if (fin_go && do_ins_w) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (fin_go && do_del_w) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign ctrl.ld_flags = (phase_r == PH_CMP);
  assign ctrl.do_ins   = fin_go && do_ins_w;
  assign ctrl.do_del   = fin_go && do_del_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tdata;
      kind_r <= in_tuser;
    end
    if (phase_r == PH_CMP) begin
      sel_ok_r  <= ($signed(op33) >= 33'sd1) && ($signed(op33) <= $signed(cnt33));
      sel_grp_r <= idx_w[LW +: GW];
      sel_loc_r <= idx_w[LW-1:0];
    end
    if (fin_go) begin
      out_status_r <= status_w;
      out_count_r  <= (kind_r == osset_pkg::REQ_CNT) ? pos_ext[OW-1:0] : '0;
      out_key_r    <= ((kind_r == osset_pkg::REQ_SEL) && sel_ok_r) ? grp_key[sel_grp_r] : '0;
    end
  end

  // Cell chain; slots past the capacity read as empty.
  for (genvar s = 0; s < NSLOT; s++) begin : g_slot
    if (s < CAPACITY) begin : g_cell
      osset_cell #(
        .CNT_W (CNT_W),
        .IDX   (s)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .count     (count_r),
        .op        (op_r),
        .left_lt   ((s == 0) ? 1'b1 : slot_lt[(s == 0) ? 0 : s - 1]),
        .left_key  ((s == 0) ? op_r : slot_key[(s == 0) ? 0 : s - 1]),
        .right_key (slot_key[s + 1]),
        .lt_r      (slot_lt[s]),
        .eq_r      (slot_eq[s]),
        .key_r     (slot_key[s])
      );
    end else begin : g_pad
      assign slot_lt[s]  = 1'b0;
      assign slot_eq[s]  = 1'b0;
      assign slot_key[s] = '0;
    end
  end

  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    osset_group #(
      .GRP (GRP)
    ) u_group (
      .clk     (clk),
      .rst_n   (rst_n),
      .load    (phase_r == PH_GRP),
      .left_lt ((g == 0) ? 1'b1 : slot_lt[(g == 0) ? 0 : g * GRP - 1]),
      .lt      (slot_lt[g * GRP +: GRP]),
      .eq      (slot_eq[g * GRP +: GRP]),
      .keys    (slot_key[g * GRP +: GRP]),
      .sel_loc (sel_loc_r),
      .hasb_r  (grp_hasb[g]),
      .bidx_r  (grp_bidx[g]),
      .eqany_r (grp_eq[g]),
      .key_r   (grp_key[g])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(48 - OW - KW){1'b0}}, out_key_r, out_count_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("key count exceeds capacity");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(phase_r) == PH_FIN)
    else $error("result beat raised outside the finish step");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && do_ins_w) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the set by one");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && (status_w == osset_pkg::ST_FULL)) |-> full_w && !do_ins_w)
    else $error("full status without a full set");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> !in_acc)
    else $error("request accepted while one is in flight");
`endif

endmodule
